// ===== rtl/core/byte_stream_frame_extractor_defines.svh =====
// assertion macros for the frame extractor
`ifndef BYTE_STREAM_FRAME_EXTRACTOR_DEFINES_SVH
`define BYTE_STREAM_FRAME_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BSFE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bsfe assertion failed");
`define BSFE_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("bsfe assertion failed");
`else
`define BSFE_ASSERT(name, prop)
`define BSFE_ASSERT_NEXT(name, pre, post)
`endif

`endif

// ===== rtl/core/bsfe_pkg.sv =====
package bsfe_pkg;

  localparam int BufferDepthDef = 64;
  localparam int FlagBytes      = 4;

  // register reset values
  localparam logic [1:0]  FrameModeRst  = 2'd0;
  localparam logic [6:0]  MaxFrameRst   = 7'd64;
  localparam logic [6:0]  FixedLenRst   = 7'd8;

  typedef enum logic [1:0] {
    MODE_PASS  = 2'd0,
    MODE_FIXED = 2'd1,
    MODE_FLAGS = 2'd2,
    MODE_LEN   = 2'd3
  } frame_mode_e;

  typedef enum logic [3:0] {
    REG_FRAME_MODE = 4'd0,
    REG_MAX_FRAME  = 4'd1,
    REG_FIXED_LEN  = 4'd2,
    REG_START_FLAG = 4'd3,
    REG_END_FLAG   = 4'd4,
    REG_FLAG_LENS  = 4'd5,
    REG_LEN_LAYOUT = 4'd6,
    REG_LEN_ADJ    = 4'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OVF,
    ST_SCAN,
    ST_SRCH,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    ACT_WAIT,
    ACT_DROP,
    ACT_EMIT,
    ACT_SEARCH
  } act_e;

  // strobes shared by every cell of the row
  typedef struct packed {
    logic shift_main;
    logic load_scan;
    logic shift_scan;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/byte_stream_frame_extractor.sv =====
// Byte stream frame extractor. Bytes come in on the s_axis side one per
// request and are held in a row of cells; complete frames leave on the
// m_axis side one byte per request with tlast on the final byte, and an
// overflow leaves as a single request with tdata zero, tlast and tuser set.
// Each byte is accepted, then the held bytes are decided on; every byte sent
// out and every byte dropped is a further step. Flag and length field
// searches walk a probe copy of the row one cell per cycle. Configuration
// is taken at any time but must only change while the block is idle.
`include "byte_stream_frame_extractor_defines.svh"

module byte_stream_frame_extractor
  import bsfe_pkg::*;
#(
  parameter int BufferDepth = BufferDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // frame_byte
  output logic        m_axis_tlast_o,   // frame_last
  output logic        m_axis_tuser_o,   // overflow
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int CntW = $clog2(BufferDepth + 1);
  localparam int IdxW = $clog2(BufferDepth);

  // configuration registers
  frame_mode_e        mode_q;
  logic [6:0]         max_frame_q, fixed_len_q;
  logic [31:0]        start_flag_q, end_flag_q;
  logic [5:0]         flag_lens_q;
  logic [8:0]         len_layout_q;
  logic [7:0]         len_adj_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= frame_mode_e'(FrameModeRst);
      max_frame_q  <= MaxFrameRst;
      fixed_len_q  <= FixedLenRst;
      start_flag_q <= '0;
      end_flag_q   <= '0;
      flag_lens_q  <= '0;
      len_layout_q <= '0;
      len_adj_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_MODE: mode_q       <= frame_mode_e'(cfg_data_i[1:0]);
        REG_MAX_FRAME:  max_frame_q  <= cfg_data_i[6:0];
        REG_FIXED_LEN:  fixed_len_q  <= cfg_data_i[6:0];
        REG_START_FLAG: start_flag_q <= cfg_data_i;
        REG_END_FLAG:   end_flag_q   <= cfg_data_i;
        REG_FLAG_LENS:  flag_lens_q  <= cfg_data_i[5:0];
        REG_LEN_LAYOUT: len_layout_q <= cfg_data_i[8:0];
        REG_LEN_ADJ:    len_adj_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // control state
  state_e          state_q, state_d;
  logic [CntW-1:0] held_q, held_d;
  logic [CntW-1:0] q_q, q_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic            m_valid_q, m_valid_d;
  logic [7:0]      m_byte_q, m_byte_d;
  logic            m_last_q, m_last_d;
  logic            m_ovf_q, m_ovf_d;

  logic       in_acc, ovf_hit, can_load, out_load, append;
  cell_ctrl_t ctrl;
  act_e       act;
  logic [7:0] emit_len;

  logic [7:0] main_w [BufferDepth];
  logic [7:0] scan_w [BufferDepth];

  // row of cells
  for (genvar i = 0; i < BufferDepth; i++) begin : g_cell
    logic [7:0] main_next, scan_next;
    if (i == BufferDepth - 1) begin : g_end
      assign main_next = '0;
      assign scan_next = '0;
    end else begin : g_mid
      assign main_next = main_w[i+1];
      assign scan_next = scan_w[i+1];
    end
    bsfe_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .wr_en_i     (append && (held_q[IdxW-1:0] == IdxW'(i))),
      .wr_byte_i   (s_axis_tdata_i),
      .main_next_i (main_next),
      .scan_next_i (scan_next),
      .main_o      (main_w[i]),
      .scan_o      (scan_w[i])
    );
  end

  // derived settings
  logic [2:0]  s_raw, e_raw, s_len, e_len;
  logic [5:0]  fld_pos;
  logic [2:0]  fld_sz;
  logic        fld_big;
  logic [7:0]  held8, limit, min_len;

  always_comb begin
    s_raw   = flag_lens_q[2:0];
    e_raw   = flag_lens_q[5:3];
    s_len   = (s_raw > 3'(FlagBytes)) ? 3'(FlagBytes) : s_raw;
    e_len   = (e_raw > 3'(FlagBytes)) ? 3'(FlagBytes) : e_raw;
    fld_pos = len_layout_q[5:0];
    fld_sz  = {1'b0, len_layout_q[7:6]} + 3'd1;
    fld_big = len_layout_q[8];
    held8   = 8'(held_q);
    limit   = ({1'b0, max_frame_q} < 8'(BufferDepth)) ? {1'b0, max_frame_q}
                                                       : 8'(BufferDepth);
    min_len = 8'(fld_pos) + 8'(fld_sz);
  end

  // flag compares on the first cells of the row and of the probe
  logic start_ok, end_ok;

  always_comb begin
    start_ok = 1'b1;
    end_ok   = 1'b1;
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < s_len && 8'(j) < held8 && main_w[j] != start_flag_q[8*j +: 8]) begin
        start_ok = 1'b0;
      end
      if (3'(j) < e_len && scan_w[j] != end_flag_q[8*j +: 8]) begin
        end_ok = 1'b0;
      end
    end
  end

  // length field value from the probe front
  logic [31:0]       fld_val;
  logic [1:0]        fld_idx;
  logic signed [9:0] total;

  always_comb begin
    fld_val = '0;
    fld_idx = '0;
    for (int i = 0; i < 4; i++) begin
      fld_idx = fld_big ? 2'(i) : 2'(fld_sz - 3'(i) - 3'd1);
      if (3'(i) < fld_sz) begin
        fld_val = {fld_val[23:0], scan_w[fld_idx]};
      end
    end
    total = $signed(10'(min_len)) + $signed(10'(fld_val[6:0]))
          + $signed({{2{len_adj_q[7]}}, len_adj_q});
  end

  // what to do with the held bytes this cycle
  always_comb begin
    act      = ACT_WAIT;
    emit_len = '0;
    case (state_q)
      ST_SCAN: begin
        if (held_q != '0) begin
          case (mode_q)
            MODE_PASS: begin
              act      = ACT_EMIT;
              emit_len = held8;
            end
            MODE_FIXED: begin
              if (fixed_len_q != '0 && held8 >= {1'b0, fixed_len_q}) begin
                act      = ACT_EMIT;
                emit_len = {1'b0, fixed_len_q};
              end
            end
            MODE_FLAGS: begin
              if (s_len != '0 && !start_ok) begin
                act = ACT_DROP;
              end else if (held8 >= 8'(s_len) && e_len != '0) begin
                act = ACT_SEARCH;
              end
            end
            default: begin
              if (held8 >= min_len) begin
                act = ACT_SEARCH;
              end
            end
          endcase
        end
      end
      ST_SRCH: begin
        case (mode_q)
          MODE_FLAGS: begin
            if (8'(q_q) < 8'(s_len)) begin
              act = ACT_SEARCH;
            end else if (8'(q_q) + 8'(e_len) > held8) begin
              act = ACT_WAIT;
            end else if (end_ok) begin
              act      = ACT_EMIT;
              emit_len = 8'(q_q) + 8'(e_len);
            end else begin
              act = ACT_SEARCH;
            end
          end
          MODE_LEN: begin
            if (8'(q_q) < 8'(fld_pos)) begin
              act = ACT_SEARCH;
            end else if (fld_val > 32'(max_frame_q) || total < 10'sd1) begin
              act = ACT_DROP;
            end else if ($signed(10'(held_q)) >= total) begin
              act      = ACT_EMIT;
              emit_len = 8'(total);
            end
          end
          default: act = ACT_WAIT;
        endcase
      end
      default: act = ACT_WAIT;
    endcase
  end

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign ovf_hit  = (held8 + 8'd1) > limit;
  assign can_load = !m_valid_q || m_axis_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ovf_hit ? ST_OVF : ST_SCAN;
      ST_OVF:  if (can_load) state_d = ST_IDLE;
      ST_SCAN, ST_SRCH: begin
        unique case (act)
          ACT_WAIT:   state_d = ST_IDLE;
          ACT_DROP:   state_d = ST_SCAN;
          ACT_EMIT:   state_d = ST_EMIT;
          ACT_SEARCH: state_d = ST_SRCH;
          default:    state_d = ST_IDLE;
        endcase
      end
      ST_EMIT: if (can_load && rem_q == CntW'(1)) state_d = ST_SCAN;
      default: state_d = ST_IDLE;
    endcase
  end

  // strobes
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    append          = in_acc && !ovf_hit;
    out_load        = (state_q == ST_OVF || state_q == ST_EMIT) && can_load;
    ctrl.shift_main = (state_q == ST_EMIT && can_load)
                   || ((state_q == ST_SCAN || state_q == ST_SRCH) && act == ACT_DROP);
    ctrl.load_scan  = (state_q == ST_SCAN) && act == ACT_SEARCH;
    ctrl.shift_scan = (state_q == ST_SRCH) && act == ACT_SEARCH;
  end

  // counters and output register
  always_comb begin
    held_d    = held_q;
    q_d       = q_q;
    rem_d     = rem_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_byte_d  = m_byte_q;
    m_last_d  = m_last_q;
    m_ovf_d   = m_ovf_q;
    if (in_acc) begin
      held_d = ovf_hit ? '0 : held_q + CntW'(1);
    end
    if (ctrl.shift_main) begin
      held_d = held_q - CntW'(1);
    end
    if (ctrl.load_scan) begin
      q_d = '0;
    end else if (ctrl.shift_scan) begin
      q_d = q_q + CntW'(1);
    end
    if ((state_q == ST_SCAN || state_q == ST_SRCH) && act == ACT_EMIT) begin
      rem_d = CntW'(emit_len);
    end else if (state_q == ST_EMIT && can_load) begin
      rem_d = rem_q - CntW'(1);
    end
    if (out_load) begin
      m_valid_d = 1'b1;
      if (state_q == ST_OVF) begin
        m_byte_d = '0;
        m_last_d = 1'b1;
        m_ovf_d  = 1'b1;
      end else begin
        m_byte_d = main_w[0];
        m_last_d = (rem_q == CntW'(1));
        m_ovf_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      held_q    <= '0;
      q_q       <= '0;
      rem_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      q_q       <= q_d;
      rem_q     <= rem_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_byte_q <= m_byte_d;
    m_last_q <= m_last_d;
    m_ovf_q  <= m_ovf_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_byte_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_ovf_q;

  `BSFE_ASSERT(a_held_bound, held_q <= CntW'(BufferDepth))
  `BSFE_ASSERT_NEXT(a_accept_scans, in_acc && !ovf_hit, state_q == ST_SCAN)
  `BSFE_ASSERT_NEXT(a_emit_pops, state_q == ST_EMIT && can_load,
                    held_q == $past(held_q) - CntW'(1))
  `BSFE_ASSERT_NEXT(a_ovf_clears, in_acc && ovf_hit, held_q == '0)

endmodule

// ===== rtl/core/bsfe_cell.sv =====
module bsfe_cell
  import bsfe_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       wr_en_i,
  input  logic [7:0] wr_byte_i,
  input  logic [7:0] main_next_i,
  input  logic [7:0] scan_next_i,
  output logic [7:0] main_o,
  output logic [7:0] scan_o
);

  logic [7:0] main_q, main_d;
  logic [7:0] scan_q, scan_d;

  // held byte: append, or take the neighbor's byte when the row moves up
  always_comb begin
    main_d = main_q;
    if (wr_en_i) begin
      main_d = wr_byte_i;
    end else if (ctrl_i.shift_main) begin
      main_d = main_next_i;
    end
  end

  // probe copy that walks toward the front during a search
  always_comb begin
    scan_d = scan_q;
    if (ctrl_i.load_scan) begin
      scan_d = main_q;
    end else if (ctrl_i.shift_scan) begin
      scan_d = scan_next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    scan_q <= scan_d;
  end

  assign main_o = main_q;
  assign scan_o = scan_q;

endmodule

// ===== verif/bsfe_checker.sv =====
module bsfe_checker
  import bsfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,
  input  logic        m_axis_tlast_i,
  input  logic        m_axis_tuser_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } frame_out_t;

  // shadow copy of the registers
  frame_mode_e mode_q;
  logic [6:0]  max_size_q;
  logic [6:0]  fixed_len_q;
  logic [31:0] start_flag_q;
  logic [31:0] end_flag_q;
  logic [5:0]  flag_lens_q;
  logic [8:0]  layout_q;
  logic [7:0]  adj_q;

  // shadow byte buffer
  logic [7:0] held_bytes[BufferDepthDef];
  int         held_cnt;

  frame_out_t frames_due[$];

  function automatic void discard_front(int n);
    if (n >= held_cnt) begin
      held_cnt = 0;
    end else begin
      for (int i = 0; i < held_cnt - n; i++) held_bytes[i] = held_bytes[i + n];
      held_cnt -= n;
    end
  endfunction

  function automatic int sat_flag_len(logic [2:0] v);
    return (v > FlagBytes) ? FlagBytes : int'(v);
  endfunction

  // start/end flag search, returns frame length, 0 to wait
  function automatic int flag_frame_len();
    int  s;
    int  e;
    int  p;
    bit  found;
    bit  ok;
    s = sat_flag_len(flag_lens_q[2:0]);
    e = sat_flag_len(flag_lens_q[5:3]);
    if (s > 0) begin
      found = 0;
      p = 0;
      while (p < held_cnt && !found) begin
        ok = 1;
        for (int j = 0; j < s && p + j < held_cnt; j++)
          if (held_bytes[p + j] != start_flag_q[8*j +: 8]) ok = 0;
        if (ok) found = 1;
        else p++;
      end
      if (!found) begin
        held_cnt = 0;
        return 0;
      end
      discard_front(p);
      if (held_cnt < s) return 0;
    end
    if (e == 0) return 0;
    for (int q = s; q + e <= held_cnt; q++) begin
      ok = 1;
      for (int j = 0; j < e; j++)
        if (held_bytes[q + j] != end_flag_q[8*j +: 8]) ok = 0;
      if (ok) return q + e;
    end
    return 0;
  endfunction

  // length field decode, returns length, -1 to drop, 0 to wait
  function automatic int field_frame_len();
    int     pos;
    int     nbytes;
    int     hdr;
    longint val;
    longint total;
    pos    = int'(layout_q[5:0]);
    nbytes = int'(layout_q[7:6]) + 1;
    hdr    = pos + nbytes;
    val    = 0;
    if (held_cnt < hdr) return 0;
    for (int i = 0; i < nbytes; i++)
      val = (val << 8) | held_bytes[layout_q[8] ? pos + i : pos + nbytes - 1 - i];
    if (val > max_size_q) return -1;
    total = hdr + val + longint'($signed(adj_q));
    if (total < 1) return -1;
    if (held_cnt >= total) return int'(total);
    return 0;
  endfunction

  function automatic int next_frame_len();
    case (mode_q)
      MODE_PASS:  return held_cnt;
      MODE_FIXED: return (fixed_len_q > 0 && held_cnt >= fixed_len_q) ? int'(fixed_len_q) : 0;
      MODE_FLAGS: return flag_frame_len();
      default:    return field_frame_len();
    endcase
  endfunction

  // append one byte and collect every frame it completes, or record an overflow
  function automatic void predict_frames(logic [7:0] rx);
    int limit;
    int len;
    bit done;
    limit = (max_size_q < BufferDepthDef) ? int'(max_size_q) : BufferDepthDef;
    if (held_cnt + 1 > limit) begin
      held_cnt = 0;
      frames_due.push_back('{data: 8'h00, last: 1'b1, ovf: 1'b1});
      return;
    end
    held_bytes[held_cnt] = rx;
    held_cnt++;
    done = 0;
    while (held_cnt > 0 && !done) begin
      len = next_frame_len();
      if (len > 0) begin
        if (len > held_cnt) len = held_cnt;
        for (int i = 0; i < len; i++)
          frames_due.push_back('{data: held_bytes[i], last: (i + 1 == len), ovf: 1'b0});
        discard_front(len);
      end else if (len < 0) begin
        discard_front(1);
      end else begin
        done = 1;
      end
    end
  endfunction

  // watch config, input and output requests
  always @(posedge clk_i or negedge rst_ni) begin
    frame_out_t want;
    if (!rst_ni) begin
      mode_q       = frame_mode_e'(FrameModeRst);
      max_size_q   = MaxFrameRst;
      fixed_len_q  = FixedLenRst;
      start_flag_q = '0;
      end_flag_q   = '0;
      flag_lens_q  = '0;
      layout_q     = '0;
      adj_q        = '0;
      held_cnt     = 0;
      fail_count_o = 0;
      frames_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_FRAME_MODE: mode_q       = frame_mode_e'(cfg_data_i[1:0]);
          REG_MAX_FRAME:  max_size_q   = cfg_data_i[6:0];
          REG_FIXED_LEN:  fixed_len_q  = cfg_data_i[6:0];
          REG_START_FLAG: start_flag_q = cfg_data_i;
          REG_END_FLAG:   end_flag_q   = cfg_data_i;
          REG_FLAG_LENS:  flag_lens_q  = cfg_data_i[5:0];
          REG_LEN_LAYOUT: layout_q     = cfg_data_i[8:0];
          REG_LEN_ADJ:    adj_q        = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) predict_frames(s_axis_tdata_i);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (frames_due.size() == 0) begin
          if (fail_count_o < 10)
            $display("unexpected output: data %h last %b ovf %b",
                     m_axis_tdata_i, m_axis_tlast_i, m_axis_tuser_i);
          fail_count_o++;
        end else begin
          want = frames_due.pop_front();
          if (want.data !== m_axis_tdata_i || want.last !== m_axis_tlast_i ||
              want.ovf !== m_axis_tuser_i) begin
            if (fail_count_o < 10)
              $display("mismatch: expected data %h last %b ovf %b, got %h %b %b",
                       want.data, want.last, want.ovf,
                       m_axis_tdata_i, m_axis_tlast_i, m_axis_tuser_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = frames_due.size();
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import bsfe_pkg::*;

  localparam int          CycleLimit  = 2000000;
  localparam int          SettleWait  = 4000;
  localparam int          RandomBytes = 230;
  localparam logic [3:0]  CfgBadIndex = 4'd9;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [31:0] cfg_data;

  int fail_count;
  int pending;
  int cycle_cnt;
  int rand_sent;
  bit no_idle;
  bit long_hold_go;
  bit long_hold_seen;
  int rx_gap;

  byte_stream_frame_extractor u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  bsfe_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .m_axis_tuser_i  (m_axis_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // output side: random gaps, one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    int g;
    if (!rst_ni) begin
      m_axis_tready  <= 1'b0;
      rx_gap         <= 0;
      long_hold_seen <= 1'b0;
    end else if (long_hold_go && !long_hold_seen) begin
      long_hold_seen <= 1'b1;
      rx_gap         <= 400;
      m_axis_tready  <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap        <= rx_gap - 1;
      m_axis_tready <= (rx_gap == 1);
    end else if (m_axis_tready && m_axis_tvalid) begin
      g = no_idle ? 0 : $urandom_range(0, 3);
      rx_gap        <= g;
      m_axis_tready <= (g == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int g;
    g = no_idle ? 0 : $urandom_range(0, 3);
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // holds valid across back-to-back writes, caller lowers it
  task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  task automatic configure(input frame_mode_e md, input int mx, input int fx,
                           input logic [31:0] sf, input logic [31:0] ef,
                           input logic [5:0] fl, input logic [8:0] lay, input int adj);
    logic [7:0] adj_b;
    adj_b = adj[7:0];
    write_reg(REG_FRAME_MODE, 32'(md));
    write_reg(REG_MAX_FRAME,  32'(mx));
    write_reg(REG_FIXED_LEN,  32'(fx));
    write_reg(REG_START_FLAG, sf);
    write_reg(REG_END_FLAG,   ef);
    write_reg(REG_FLAG_LENS,  32'(fl));
    write_reg(REG_LEN_LAYOUT, 32'(lay));
    write_reg(REG_LEN_ADJ,    {24'h0, adj_b});
    cfg_valid <= 1'b0;
  endtask

  // sender pauses until all frames are out, then lets rescans settle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic send_rand(input logic [7:0] b);
    send_byte(b);
    rand_sent++;
  endtask

  // noise, start flag, payload, end flag
  task automatic flag_frame(input logic [31:0] sf, input logic [31:0] ef,
                            input int s, input int e);
    int n;
    n = $urandom_range(0, 2);
    repeat (n) send_rand(8'($urandom));
    for (int j = 0; j < s; j++) send_rand(sf[8*j +: 8]);
    n = $urandom_range(0, 6);
    repeat (n) send_rand(8'($urandom));
    for (int j = 0; j < e; j++) send_rand(ef[8*j +: 8]);
  endtask

  // header, length field, payload
  task automatic field_frame(input int pos, input int nb, input bit big, input int adj);
    longint val;
    int     rest;
    val = $urandom_range(0, 8);
    for (int i = 0; i < pos; i++) send_rand(8'($urandom));
    for (int i = 0; i < nb; i++) send_rand(8'(val >> (8 * (big ? nb - 1 - i : i))));
    rest = int'(val) + adj;
    for (int i = 0; i < rest; i++) send_rand(8'($urandom));
  endtask

  initial begin
    frame_mode_e md;
    int          mx, fx, s, e, pos, nb, adj, n;
    bit          big;
    logic [31:0] sf, ef;
    logic [5:0]  fl;
    logic [8:0]  lay;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    cfg_valid     <= 1'b0;
    cfg_index     <= 4'd0;
    cfg_data      <= 32'd0;
    no_idle       <= 1'b0;
    long_hold_go  <= 1'b0;
    rand_sent     = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pass-through from reset, and an ignored register index
    write_reg(CfgBadIndex, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send_byte(8'h00);
    send_byte(8'hFF);
    settle();

    // zero max size: every byte overflows
    configure(MODE_PASS, 0, 8, 32'h0, 32'h0, 6'd0, 9'd0, 0);
    send_byte(8'h5A);
    settle();

    // fixed length, then zero length gathering until overflow
    configure(MODE_FIXED, 64, 3, 32'h0, 32'h0, 6'd0, 9'd0, 0);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h7F);
    settle();
    configure(MODE_FIXED, 2, 0, 32'h0, 32'h0, 6'd0, 9'd0, 0);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    settle();

    // flags with leading noise, flag lengths saturated
    configure(MODE_FLAGS, 64, 8, 32'hFFFF_A55A, 32'h0000_0A0D, 6'd2 | (6'd2 << 3),
              9'd0, 0);
    send_byte(8'h11);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_byte(8'h42);
    send_byte(8'h0D);
    send_byte(8'h0A);
    settle();
    configure(MODE_FLAGS, 64, 8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F, 9'd0, 0);
    repeat (4) send_byte(8'hFF);
    settle();

    // length field: too large, extreme adjustments
    configure(MODE_LEN, 64, 8, 32'h0, 32'h0, 6'd0, 9'h141, -64);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h41);
    send_byte(8'h00);
    settle();
    configure(MODE_LEN, 64, 64, 32'h0, 32'h0, 6'd0, 9'h000, 64);
    send_byte(8'h00);
    settle();

    // long receiver hold-off so the block fills and stalls input
    configure(MODE_FIXED, 64, 64, 32'h0, 32'h0, 6'd0, 9'd0, 0);
    long_hold_go <= 1'b1;
    no_idle      <= 1'b1;
    repeat (130) send_rand(8'($urandom));
    settle();

    // random phases, mostly well-formed frames
    while (rand_sent < RandomBytes) begin
      md      = frame_mode_e'($urandom_range(0, 3));
      no_idle <= ($urandom_range(0, 4) == 0);
      mx      = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : 64;
      case (md)
        MODE_PASS: begin
          configure(md, $urandom_range(1, 64), 8, 32'h0, 32'h0, 6'd0, 9'd0, 0);
          repeat (8) send_rand(8'($urandom));
        end
        MODE_FIXED: begin
          fx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
          configure(md, mx, fx, 32'h0, 32'h0, 6'd0, 9'd0, 0);
          n = $urandom_range(10, 25);
          repeat (n) send_rand(8'($urandom));
        end
        MODE_FLAGS: begin
          sf = $urandom;
          ef = $urandom;
          fl = ($urandom_range(0, 7) == 0) ? 6'($urandom) :
               6'($urandom_range(0, 4)) | (6'($urandom_range(1, 4)) << 3);
          s  = (fl[2:0] > 4) ? 4 : int'(fl[2:0]);
          e  = (fl[5:3] > 4) ? 4 : int'(fl[5:3]);
          configure(md, mx, 8, sf, ef, fl, 9'd0, 0);
          repeat (2) flag_frame(sf, ef, s, e);
        end
        default: begin
          if ($urandom_range(0, 7) == 0) lay = 9'($urandom);
          else lay = 9'($urandom_range(0, 3)) | (9'($urandom_range(0, 1)) << 6) |
                     (9'($urandom_range(0, 1)) << 8);
          pos = int'(lay[5:0]);
          nb  = int'(lay[7:6]) + 1;
          big = lay[8];
          adj = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 128) - 64 :
                $urandom_range(0, 8) - 4;
          configure(md, mx, 8, 32'h0, 32'h0, 6'd0, lay, adj);
          n = $urandom_range(2, 3);
          repeat (n) begin
            if ($urandom_range(0, 4) == 0) send_rand(8'($urandom));
            field_frame((pos > 6) ? 6 : pos, nb, big, adj);
          end
        end
      endcase
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== byte_stream_frame_extractor.f =====
+incdir+rtl/core
rtl/core/bsfe_pkg.sv
rtl/core/bsfe_cell.sv
rtl/core/byte_stream_frame_extractor.sv
verif/bsfe_checker.sv
verif/tb_top.sv
